@@ rtl/rcpw_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpw_pkg
// Item types and fixed constants shared by the RC pulse-width capture block.
// ----------------------------------------------------------------------------
package rcpw_pkg;

   localparam logic       OP_EDGE       = 1'b0;
   localparam logic       OP_TICK       = 1'b1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] WORD_MAX      = 16'hFFFF;
   localparam int         MASK_BITS     = 8;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  channel;
      logic        pin_level;
      logic [15:0] timestamp;
      logic [7:0]  tick_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] pulse_width;
      logic [7:0]  enable_mask;
   } rsp_type;

endpackage

@@ rtl/rcpw_channel_bank.sv @@
// ----------------------------------------------------------------------------
// rcpw_channel_bank
// Per-channel rise time, width and watchdog registers; applies one item and
// presents the result it produces.
// ----------------------------------------------------------------------------
module rcpw_channel_bank #(
   parameter int CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  rcpw_pkg::req_type item,
   input  logic [15:0]       timeout,
   output rcpw_pkg::rsp_type result
);

   localparam int MASK_W = (CHANNELS < rcpw_pkg::MASK_BITS) ? CHANNELS : rcpw_pkg::MASK_BITS;

   logic [15:0] rise_ff  [CHANNELS];
   logic [15:0] rise_in  [CHANNELS];
   logic [15:0] width_ff [CHANNELS];
   logic [15:0] width_in [CHANNELS];
   logic [15:0] count_ff [CHANNELS];
   logic [15:0] count_in [CHANNELS];
   logic [7:0]  en_ff;
   logic [7:0]  en_in;

   logic [CHANNELS-1:0] hit;
   logic [CHANNELS-1:0] live;
   logic [15:0]         sel [CHANNELS+1];

   logic is_tick;
   assign is_tick = (item.opcode == rcpw_pkg::OP_TICK);

   assign sel[0] = 16'd0;

   genvar g;
   generate
      for (g = 0; g < CHANNELS; g++) begin : g_ch
         logic [16:0] sum;

         assign hit[g]  = ({29'd0, item.channel} == 32'(g));
         assign live[g] = (count_ff[g] < timeout);
         assign sum     = {1'b0, count_ff[g]} + {9'd0, item.tick_ms};

         always_comb begin
            rise_in[g]  = rise_ff[g];
            width_in[g] = width_ff[g];
            count_in[g] = count_ff[g];
            if (is_tick) begin
               if (live[g]) begin
                  count_in[g] = sum[16] ? rcpw_pkg::WORD_MAX : sum[15:0];
               end else begin
                  width_in[g] = 16'd0;
               end
            end else if (hit[g]) begin
               count_in[g] = 16'd0;
               if (item.pin_level) begin
                  rise_in[g] = item.timestamp;
               end else begin
                  width_in[g] = item.timestamp - rise_ff[g];
               end
            end
         end

         assign sel[g+1] = sel[g] | (hit[g] ? width_in[g] : 16'd0);

         always_ff @(posedge clock) begin
            if (reset) begin
               rise_ff[g]  <= 16'd0;
               width_ff[g] <= 16'd0;
               count_ff[g] <= 16'd0;
            end else if (update) begin
               rise_ff[g]  <= rise_in[g];
               width_ff[g] <= width_in[g];
               count_ff[g] <= count_in[g];
            end
         end
      end
   endgenerate

   assign en_in = is_tick ? 8'(live[MASK_W-1:0]) : en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 8'd0;
      end else if (update) begin
         en_ff <= en_in;
      end
   end

   assign result.pulse_width = sel[CHANNELS];
   assign result.enable_mask = en_in;

endmodule

@@ rtl/rc_pulse_width_capture_watchdog.sv @@
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_watchdog
// RC pulse-width capture with a per-channel signal-loss watchdog.
//
// req_* carries one item: a capture edge (channel, pin level, timestamp) or a
// tick (tick_ms) that ages every channel against csr timeout_ms.
// rsp_* returns one item per request: the addressed channel's width and the
// enable mask, both after the update.
// csr_wr_en / csr_wr_data write timeout_ms (reset 500); write only when idle.
// An accepted item passes the input register, then the result register, where
// rsp_valid rises. Throughput: one item per cycle unless stalled; the bank
// updates all channels in parallel as an item leaves the input register.
// A stalled result holds in the result register while one more item is taken
// into the input register; req_stall rises once both are full.
// Reset (synchronous) clears all channel state, the enable mask, both
// pipeline valids and restores the timeout.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture_watchdog #(
   parameter int CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcpw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcpw_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   logic              in_valid_ff;
   rcpw_pkg::req_type in_item_ff;
   logic              rsp_valid_ff;
   rcpw_pkg::rsp_type rsp_item_ff;
   logic [15:0]       timeout_ff;
   rcpw_pkg::rsp_type bank_result;
   logic              move;
   logic              req_fire;

   assign move      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= rcpw_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_data;
      end
   end

   rcpw_channel_bank #(
      .CHANNELS (CHANNELS)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .update  (move),
      .item    (in_item_ff),
      .timeout (timeout_ff),
      .result  (bank_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_item_ff <= bank_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

`ifndef ASSERT_OFF
   localparam int MASK_W = (CHANNELS < rcpw_pkg::MASK_BITS) ? CHANNELS : rcpw_pkg::MASK_BITS;
   localparam logic [7:0] LIVE_MASK = 8'((17'd1 << MASK_W) - 17'd1);

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input register empty but request stalled");

   a_move_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("item moved but no result presented");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !in_valid_ff |=> !rsp_valid_ff)
      else $error("result repeated after being taken");

   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_item_ff.enable_mask & ~LIVE_MASK) == 8'd0))
      else $error("enable bit set for a missing channel");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !in_valid_ff))
      else $error("pipeline valid after reset");
`endif

endmodule
